### rtl/round_robin_slice_scheduler_top_defines.svh
// Assertion macros used by the round-robin slice scheduler top level.
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define RRS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the cycle after the antecedent.
`define RRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rrs_pkg.sv
// Shared constants and types of the round-robin slice scheduler.
package rrs_pkg;

  localparam int unsigned MAX_PROCESSES_DEF = 16;

  localparam int unsigned CMD_W        = 2;
  localparam int unsigned BURST_W      = 16;
  localparam int unsigned QUANTUM_W    = 16;
  localparam int unsigned TIME_W       = 20;
  localparam int unsigned SLICE_PROC_W = 4;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned IN_DATA_W    = 16;
  localparam int unsigned OUT_DATA_W   = 32;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

  // Register index, taken from the word address.
  localparam logic REG_QUANTUM = 1'b0;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 16'd4;

  // One scheduling result.
  typedef struct packed {
    logic                    all_done;
    logic                    process_finished;
    logic [TIME_W-1:0]       slice_end_time;
    logic [SLICE_PROC_W-1:0] slice_process;
  } res_t;

endpackage

### rtl/rrs_mem.sv
// Remaining-burst table: one write port, one read port, registered read data.
module rrs_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rrs_cfg.sv
// Configuration register block holding the time quantum.
module rrs_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rrs_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [rrs_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [rrs_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  output logic [rrs_pkg::QUANTUM_W-1:0]       quantum_o
);
  import rrs_pkg::*;

  logic [QUANTUM_W-1:0] quantum_q;
  logic                 reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_QUANTUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RST;
    end else if (wr_en) begin
      quantum_q <= pwdata[QUANTUM_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_QUANTUM) begin
      prdata = APB_DATA_W'(quantum_q);
    end
  end

  assign quantum_o = quantum_q;

endmodule

### rtl/rrs_sched.sv
// Scheduler sequencer: table scan, slice grant and bookkeeping.
module rrs_sched #(
  parameter int unsigned MAX_PROCESSES = 16,
  parameter int unsigned IDX_W         = 4,
  parameter int unsigned CNT_W         = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  logic [rrs_pkg::CMD_W-1:0]        req_cmd_i,
  input  logic [rrs_pkg::BURST_W-1:0]      req_burst_i,
  input  logic [rrs_pkg::QUANTUM_W-1:0]    quantum_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output rrs_pkg::res_t                    res_o,
  output logic [CNT_W-1:0]                 proc_cnt_o,
  output logic [CNT_W-1:0]                 fin_cnt_o
);
  import rrs_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_OUT    = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCESSES);

  logic [1:0]           state_q, state_d;
  logic [CNT_W-1:0]     proc_cnt_q, fin_cnt_q;
  logic [IDX_W-1:0]     scan_q;
  logic [TIME_W-1:0]    time_q;
  logic [IDX_W-1:0]     ptr_q;
  logic                 chk_q;
  logic [IDX_W-1:0]     chk_idx_q;
  logic [IDX_W-1:0]     idx_q;
  logic [BURST_W-1:0]   rem_q;
  res_t                 res_q;

  logic                 accept;
  logic                 load_wr;
  logic                 found;
  logic [BURST_W-1:0]   rd_data;
  logic [QUANTUM_W-1:0] quantum_eff;
  logic [BURST_W-1:0]   slice;
  logic [BURST_W-1:0]   rem_new;
  logic [CNT_W-1:0]     fin_new;
  logic [TIME_W-1:0]    time_new;
  logic [IDX_W-1:0]     start_idx;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [BURST_W-1:0]   mem_wdata;

  // Cyclic successor of a table index within the loaded entries.
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(idx) + 1'b1;
    if (sum == (CNT_W+1)'(cnt)) begin
      next_idx = '0;
    end else begin
      next_idx = IDX_W'(sum);
    end
  endfunction

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign load_wr     = accept && (req_cmd_i == CMD_LOAD) && (proc_cnt_q < CNT_MAX);
  assign found       = (state_q == ST_SCAN) && chk_q && (rd_data != '0);
  assign start_idx   = (CNT_W'(scan_q) < proc_cnt_q) ? scan_q : '0;

  assign quantum_eff = (quantum_i == '0) ? QUANTUM_W'(1) : quantum_i;
  assign slice       = (rem_q < quantum_eff) ? rem_q : quantum_eff;
  assign rem_new     = rem_q - slice;
  assign fin_new     = fin_cnt_q + CNT_W'(rem_new == '0);
  assign time_new    = time_q + TIME_W'(slice);

  // Loads write in the idle state and grants in the update state, so the two
  // never collide; a scan read always comes after the last write.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = rem_new;
    if (load_wr) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_W'(proc_cnt_q);
      mem_wdata = req_burst_i;
    end else if (state_q == ST_UPDATE) begin
      mem_we = 1'b1;
    end
  end

  rrs_mem #(
    .DEPTH  (MAX_PROCESSES),
    .ADDR_W (IDX_W),
    .DATA_W (BURST_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (state_q == ST_SCAN),
    .raddr_i (ptr_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req_cmd_i == CMD_STEP)) begin
          state_d = (fin_cnt_q >= proc_cnt_q) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (found) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      proc_cnt_q <= '0;
      fin_cnt_q  <= '0;
      scan_q     <= '0;
      time_q     <= '0;
      chk_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && (req_cmd_i == CMD_CLEAR)) begin
        proc_cnt_q <= '0;
        fin_cnt_q  <= '0;
        scan_q     <= '0;
        time_q     <= '0;
      end
      if (load_wr) begin
        proc_cnt_q <= proc_cnt_q + 1'b1;
        if (req_burst_i == '0) begin
          fin_cnt_q <= fin_cnt_q + 1'b1;
        end
      end
      if (state_q == ST_UPDATE) begin
        fin_cnt_q <= fin_new;
        time_q    <= time_new;
        scan_q    <= next_idx(idx_q, proc_cnt_q);
      end
      if (state_q == ST_SCAN && !found) begin
        chk_q <= 1'b1;
      end else begin
        chk_q <= 1'b0;
      end
    end
  end

  // Scan pointer and result payload carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept && (req_cmd_i == CMD_STEP)) begin
      ptr_q <= start_idx;
      res_q <= '{all_done: 1'b1, process_finished: 1'b0,
                 slice_end_time: '0, slice_process: '0};
    end
    if (state_q == ST_SCAN) begin
      ptr_q     <= next_idx(ptr_q, proc_cnt_q);
      chk_idx_q <= ptr_q;
    end
    if (found) begin
      idx_q <= chk_idx_q;
      rem_q <= rd_data;
    end
    if (state_q == ST_UPDATE) begin
      res_q.slice_process    <= SLICE_PROC_W'(idx_q);
      res_q.slice_end_time   <= time_new;
      res_q.process_finished <= (rem_new == '0);
      res_q.all_done         <= (fin_new >= proc_cnt_q);
    end
  end

  assign res_valid_o = (state_q == ST_OUT);
  assign res_o       = res_q;
  assign proc_cnt_o  = proc_cnt_q;
  assign fin_cnt_o   = fin_cnt_q;

endmodule

### rtl/round_robin_slice_scheduler_top.sv
// Round-robin slice scheduler: top level with APB register, sequencer and output register.
// Clear, load and unused requests return nothing.
// A step request scans 1 to MAX_PROCESSES table entries, one memory read per cycle,
// until it finds a process with time left, grants it a slice and answers; when all work
// is done the answer comes without a scan. One request at a time is taken.
// Asynchronous active-low reset clears counters, clock, pointer and quantum (to 4); the
// burst table itself is not cleared and only holds meaning once loaded.
module round_robin_slice_scheduler_top #(
  parameter int unsigned MAX_PROCESSES = rrs_pkg::MAX_PROCESSES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [rrs_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,   // [15:0] burst_time
  input  logic [rrs_pkg::CMD_W-1:0]         s_axis_tuser_i,   // [1:0] command
  // Result stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [3:0] slice_process, [23:4] slice_end_time, [24] process_finished,
  // [25] all_done, [31:26] zero
  output logic [rrs_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rrs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rrs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rrs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import rrs_pkg::*;
  `include "round_robin_slice_scheduler_top_defines.svh"

  // Table index and process count widths follow from the table depth.
  localparam int unsigned IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCESSES);

  logic [QUANTUM_W-1:0] quantum;
  logic                 res_valid;
  logic                 res_ready;
  res_t                 res;
  logic [CNT_W-1:0]     proc_cnt;
  logic [CNT_W-1:0]     fin_cnt;
  logic                 out_valid_q;
  res_t                 out_data_q;
  logic                 step_acc;

  rrs_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .quantum_o (quantum)
  );

  rrs_sched #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_cmd_i   (s_axis_tuser_i),
    .req_burst_i (s_axis_tdata_i[BURST_W-1:0]),
    .quantum_i   (quantum),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .proc_cnt_o  (proc_cnt),
    .fin_cnt_o   (fin_cnt)
  );

  // The output register frees the sequencer as soon as a result is parked here,
  // so the next request can be taken while the consumer stalls.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_data_q);

  // A step request taken at this edge.
  assign step_acc = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == CMD_STEP);

  // The process count never passes the table depth.
  `RRS_ASSERT_ALWAYS(a_cnt_max, clk_i, rst_ni, proc_cnt <= CNT_MAX, "process count overflow")
  // Finished processes are always a subset of the loaded ones.
  `RRS_ASSERT_ALWAYS(a_fin_le_cnt, clk_i, rst_ni, fin_cnt <= proc_cnt, "finished count too large")
  // A step request occupies the sequencer in the following cycle.
  `RRS_ASSERT_NEXT(a_step_busy, clk_i, rst_ni, step_acc, !s_axis_tready_o, "step did not start")

endmodule
